[rtl/assert_macros.svh]
// Assertion macros used by the top level of the scalar estimator.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ske_pkg.sv]
// Package of the scalar estimator: field widths, register codes and payload types.
// Depends on nothing; used by the channel interfaces and the top level.
package ske_pkg;

  localparam int SampleW     = 32;
  localparam int GainInW     = 17;
  localparam int EstW        = 32;
  localparam int UncW        = 32;
  localparam int MeasErrW    = 32;
  localparam int ProcNoiseW  = 17;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 32;
  localparam int FracBitsDef = 16;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [GainInW-1:0]        gain_in_t;
  typedef logic signed [EstW-1:0]    est_t;
  typedef logic [UncW-1:0]           unc_t;
  typedef logic [CfgIdxW-1:0]        cfg_idx_t;
  typedef logic [CfgDataW-1:0]       cfg_data_t;

  // Configuration register indexes.
  localparam cfg_idx_t RegMeasErr  = 2'd0;
  localparam cfg_idx_t RegProcNois = 2'd1;
  localparam cfg_idx_t RegInitErr  = 2'd2;
  localparam cfg_idx_t RegInitEst  = 2'd3;

endpackage

[rtl/ske_channels.sv]
// Valid/ready channel interfaces of the scalar estimator: sample in, result out.
// Depends on ske_pkg for the payload types.
interface ske_in_if;
  logic               valid;
  logic               ready;
  ske_pkg::sample_t   sample;
  ske_pkg::gain_in_t  given_gain;

  modport source (output valid, output sample, output given_gain, input ready);
  modport sink   (input valid, input sample, input given_gain, output ready);
endinterface

interface ske_out_if;
  logic           valid;
  logic           ready;
  ske_pkg::est_t  estimate;
  ske_pkg::unc_t  uncertainty;

  modport source (output valid, output estimate, output uncertainty, input ready);
  modport sink   (input valid, input estimate, input uncertainty, output ready);
endinterface

[rtl/scalar_kalman_estimator.sv]
// Scalar Kalman estimator top level: sequencer, shared divider step and shared multiplier.
// Depends on ske_pkg, the channel interfaces in ske_channels.sv and assert_macros.svh.
//
//  channel      dir  payload                          transfer when
//  in_chan_i    in   sample (s32), given_gain (u17)   valid && ready
//  out_chan_o   out  estimate (s32), uncertainty (u32) valid && ready
//  cfg          in   cfg_idx_i, cfg_wdata_i           cfg_we_i
//
// Sequence: an item with a nonzero given gain goes through three multiplier passes and one
// sum (S_MUL1, S_MUL2, S_MUL3, S_SUM) before its result shows, then the sequencer returns
// to idle for the next transfer. With a zero gain the restoring divider runs first, one
// quotient bit per cycle, for FRAC_BITS+1 quotient bits; a zero denominator skips the
// divider. Reset is asynchronous and active low; it loads the configuration
// defaults and the held estimate and uncertainty. Input ready is high only while the
// sequencer is idle. The result sits in an output register; while a stalled output still
// holds the previous result, the sequencer waits in its final state and the input stalls.
`include "assert_macros.svh"

module scalar_kalman_estimator #(
  parameter int FRAC_BITS = ske_pkg::FracBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ske_in_if.sink               in_chan_i,
  ske_out_if.source            out_chan_o,
  input  logic                 cfg_we_i,
  input  ske_pkg::cfg_idx_t    cfg_idx_i,
  input  ske_pkg::cfg_data_t   cfg_wdata_i
);

  // Gains carry FRAC_BITS fraction bits and reach exactly 1.0, hence one more bit.
  localparam int GW   = FRAC_BITS + 1;
  localparam int CW   = (GW > ske_pkg::GainInW) ? GW : ske_pkg::GainInW;
  localparam int CntW = $clog2(GW + 1);
  // Product of an unsigned gain-wide operand and a 34-bit signed operand.
  localparam int PW   = GW + 35;
  localparam logic [GW-1:0] One = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [ske_pkg::ProcNoiseW-1:0] PnReset =
    ske_pkg::ProcNoiseW'((655 << FRAC_BITS) >> 16);
  localparam logic [ske_pkg::UncW-1:0] UncOne = ske_pkg::UncW'(One);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_MUL3 = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;

  logic [2:0] state_q, state_d;

  // Configuration and held filter state.
  logic [ske_pkg::MeasErrW-1:0]   meas_err_q;
  logic [ske_pkg::ProcNoiseW-1:0] pn_q;
  logic signed [31:0]             held_est_q;
  logic [31:0]                    held_unc_q;

  // Per-item working registers.
  logic signed [31:0]   sample_q;
  logic [GW-1:0]        gain_q, gain_d;
  logic [32:0]          den_q, den_d;
  logic [33:0]          rem_q, rem_d;
  logic                 nbit_q, nbit_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic signed [PW-1:0] prod_q;
  logic signed [31:0]   next_est_q, next_est_d;
  logic [32:0]          change_q, change_d;
  logic [31:0]          term_q;

  logic                 out_valid_q;
  logic signed [31:0]   out_est_q;
  logic [31:0]          out_unc_q;

  logic in_xfer, out_free, finish;

  assign in_chan_i.ready = (state_q == S_IDLE);
  assign in_xfer  = in_chan_i.valid && in_chan_i.ready;
  assign out_free = !out_valid_q || out_chan_o.ready;
  assign finish   = (state_q == S_SUM) && out_free;

  assign out_chan_o.valid       = out_valid_q;
  assign out_chan_o.estimate    = out_est_q;
  assign out_chan_o.uncertainty = out_unc_q;

  // Supplied gain: zero asks for a computed gain, anything above 1.0 counts as 1.0.
  logic [CW-1:0] given_ext, pn_ext;
  logic [GW-1:0] given_cl, q_cl;
  logic          given_zero;
  logic [32:0]   den_new;

  assign given_ext  = CW'(in_chan_i.given_gain);
  assign given_zero = (given_ext == '0);
  assign given_cl   = (given_ext > CW'(One)) ? One : given_ext[GW-1:0];
  assign pn_ext     = CW'(pn_q);
  assign q_cl       = (pn_ext > CW'(One)) ? One : pn_ext[GW-1:0];
  assign den_new    = {1'b0, held_unc_q} + {1'b0, meas_err_q};

  // One restoring divider step: shift in the next numerator bit, compare, subtract.
  logic [33:0] trial;
  logic        trial_ge;

  assign trial    = {rem_q[32:0], nbit_q};
  assign trial_ge = (trial >= {1'b0, den_q});

  // Shared multiplier; its operands are chosen by the sequencer state.
  logic [GW-1:0]        mul_a;
  logic signed [33:0]   mul_b;
  logic signed [PW-1:0] mul_p;

  always_comb begin
    mul_a = gain_q;
    mul_b = {sample_q[31], sample_q[31], sample_q} -
            {held_est_q[31], held_est_q[31], held_est_q};
    case (state_q)
      S_MUL2: begin
        mul_a = One - gain_q;
        mul_b = {2'b00, held_unc_q};
      end
      S_MUL3: begin
        mul_a = q_cl;
        mul_b = {1'b0, change_q};
      end
      default: begin
      end
    endcase
  end

  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  // Estimate update from the gain times innovation product. The arithmetic shift
  // rounds toward minus infinity, then the sum is clamped to 32 bits.
  logic signed [PW-1:0] delta, est_sum;
  logic signed [33:0]   est_diff;

  assign delta    = prod_q >>> FRAC_BITS;
  assign est_sum  = PW'(held_est_q) + delta;
  assign est_diff = {next_est_d[31], next_est_d[31], next_est_d} -
                    {held_est_q[31], held_est_q[31], held_est_q};

  always_comb begin
    if (est_sum > PW'(32'sh7FFF_FFFF)) begin
      next_est_d = 32'sh7FFF_FFFF;
    end else if (est_sum < -PW'(33'sh0_8000_0000)) begin
      next_est_d = 32'sh8000_0000;
    end else begin
      next_est_d = est_sum[31:0];
    end
    change_d = est_diff[33] ? 33'(-est_diff) : est_diff[32:0];
  end

  // New uncertainty: (1 - gain) * P plus |change| * q, saturated.
  logic [32:0] noise_term;
  logic [33:0] unc_sum;
  logic [31:0] unc_new;

  assign noise_term = prod_q[FRAC_BITS +: 33];
  assign unc_sum    = {2'b00, term_q} + {1'b0, noise_term};
  assign unc_new    = (unc_sum > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : unc_sum[31:0];

  // Sequencer and divider control.
  always_comb begin
    state_d = state_q;
    gain_d  = gain_q;
    den_d   = den_q;
    rem_d   = rem_q;
    nbit_d  = nbit_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (given_zero) begin
            gain_d  = '0;
            den_d   = den_new;
            rem_d   = {3'b000, held_unc_q[31:1]};
            nbit_d  = held_unc_q[0];
            cnt_d   = '0;
            state_d = (den_new == '0) ? S_MUL1 : S_DIV;
          end else begin
            gain_d  = given_cl;
            state_d = S_MUL1;
          end
        end
      end
      S_DIV: begin
        rem_d  = trial_ge ? (trial - {1'b0, den_q}) : trial;
        gain_d = {gain_q[GW-2:0], trial_ge};
        nbit_d = 1'b0;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CntW'(GW - 1)) begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_MUL3;
      S_MUL3: state_d = S_SUM;
      S_SUM: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control, configuration and held state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      meas_err_q  <= UncOne;
      pn_q        <= PnReset;
      held_est_q  <= '0;
      held_unc_q  <= UncOne;
    end else begin
      state_q <= state_d;
      if (finish) begin
        out_valid_q <= 1'b1;
        held_est_q  <= next_est_q;
        held_unc_q  <= unc_new;
      end else if (out_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ske_pkg::RegMeasErr:  meas_err_q <= cfg_wdata_i;
          ske_pkg::RegProcNois: pn_q       <= cfg_wdata_i[ske_pkg::ProcNoiseW-1:0];
          ske_pkg::RegInitErr:  held_unc_q <= cfg_wdata_i;
          ske_pkg::RegInitEst:  held_est_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    gain_q <= gain_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    nbit_q <= nbit_d;
    cnt_q  <= cnt_d;
    if (in_xfer) begin
      sample_q <= in_chan_i.sample;
    end
    if (state_q == S_MUL1 || state_q == S_MUL2 || state_q == S_MUL3) begin
      prod_q <= mul_p;
    end
    if (state_q == S_MUL2) begin
      next_est_q <= next_est_d;
      change_q   <= change_d;
    end
    if (state_q == S_MUL3) begin
      term_q <= prod_q[FRAC_BITS +: 32];
    end
    if (finish) begin
      out_est_q <= next_est_q;
      out_unc_q <= unc_new;
    end
  end

  // A transfer always starts work on the item.
  `ASSERT_NEXT(a_xfer_leaves_idle, in_xfer, state_q != S_IDLE, "accepted item did not start")
  // The gain used in the multiplies never exceeds one.
  `ASSERT_IMPL(a_gain_bounded, state_q == S_MUL1, gain_q <= One, "gain above one")
  // A freshly shown result equals the held estimate and uncertainty.
  `ASSERT_IMPL(a_result_held, $rose(out_valid_q),
               (out_est_q == held_est_q) && (out_unc_q == held_unc_q),
               "result differs from held state")

endmodule
